>>> hdl/xbr_pkg.sv
// ----------------------------------------------------------------------------
// xbr_pkg
// Types, constants and the control program of the bounded random unit.
// ----------------------------------------------------------------------------
package xbr_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned PC_W     = 4;
    localparam int unsigned DIV_CNT_W = 5;

    localparam logic [WORD_W-1:0] WORD_MAX = 32'hFFFF_FFFF;

    localparam logic [WORD_W-1:0] SEED_W0 = 32'hdead_beef;
    localparam logic [WORD_W-1:0] SEED_W1 = 32'hfeed_feed;
    localparam logic [WORD_W-1:0] SEED_W2 = 32'hcafe_babe;
    localparam logic [WORD_W-1:0] SEED_W3 = 32'd1234;

    localparam int unsigned GEN_SHL   = 11;
    localparam int unsigned GEN_SHR_A = 8;
    localparam int unsigned GEN_SHR_B = 19;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(WORD_W - 1);

    localparam logic       CMD_DRAW = 1'b0;
    localparam logic       CMD_SEED = 1'b1;

    // Program addresses
    localparam logic [PC_W-1:0] PC_FETCH     = 4'd0;
    localparam logic [PC_W-1:0] PC_LIM_FULL  = 4'd1;
    localparam logic [PC_W-1:0] PC_DIV_MAX   = 4'd2;
    localparam logic [PC_W-1:0] PC_DIV_A     = 4'd3;
    localparam logic [PC_W-1:0] PC_SET_LIMIT = 4'd4;
    localparam logic [PC_W-1:0] PC_GEN       = 4'd5;
    localparam logic [PC_W-1:0] PC_RAW_CHK   = 4'd6;
    localparam logic [PC_W-1:0] PC_DIV_WORD  = 4'd7;
    localparam logic [PC_W-1:0] PC_DIV_B     = 4'd8;
    localparam logic [PC_W-1:0] PC_EMIT      = 4'd9;
    localparam logic [PC_W-1:0] PC_SEED      = 4'd10;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_FETCH,
        OP_LIM_FULL,
        OP_DIV_LOAD_MAX,
        OP_DIV_LOAD_WORD,
        OP_DIV_STEP,
        OP_SET_LIMIT,
        OP_GEN,
        OP_EMIT,
        OP_SEED
    } t_op;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_SEED,
        COND_ZERO_IV,
        COND_DIV_BUSY,
        COND_REJECT
    } t_cond;

    typedef enum logic [1:0] {
        HOLD_NONE,
        HOLD_INPUT,
        HOLD_OUTPUT
    } t_hold;

    typedef struct packed {
        t_op            op;
        t_cond          cond;
        t_hold          hold;
        logic [PC_W-1:0] target;
    } t_uword;

    function automatic t_uword ucode_rom(input logic [PC_W-1:0] addr);
        t_uword w;
        w = '{op: OP_NONE, cond: COND_ALWAYS, hold: HOLD_NONE, target: PC_FETCH};
        case (addr)
            PC_FETCH: begin
                w = '{op: OP_FETCH, cond: COND_SEED, hold: HOLD_INPUT, target: PC_SEED};
            end
            PC_LIM_FULL: begin
                w = '{op: OP_LIM_FULL, cond: COND_ZERO_IV, hold: HOLD_NONE, target: PC_GEN};
            end
            PC_DIV_MAX: begin
                w = '{op: OP_DIV_LOAD_MAX, cond: COND_NEVER, hold: HOLD_NONE,
                      target: PC_FETCH};
            end
            PC_DIV_A: begin
                w = '{op: OP_DIV_STEP, cond: COND_DIV_BUSY, hold: HOLD_NONE,
                      target: PC_DIV_A};
            end
            PC_SET_LIMIT: begin
                w = '{op: OP_SET_LIMIT, cond: COND_NEVER, hold: HOLD_NONE,
                      target: PC_FETCH};
            end
            PC_GEN: begin
                w = '{op: OP_GEN, cond: COND_REJECT, hold: HOLD_NONE, target: PC_GEN};
            end
            PC_RAW_CHK: begin
                w = '{op: OP_NONE, cond: COND_ZERO_IV, hold: HOLD_NONE, target: PC_EMIT};
            end
            PC_DIV_WORD: begin
                w = '{op: OP_DIV_LOAD_WORD, cond: COND_NEVER, hold: HOLD_NONE,
                      target: PC_FETCH};
            end
            PC_DIV_B: begin
                w = '{op: OP_DIV_STEP, cond: COND_DIV_BUSY, hold: HOLD_NONE,
                      target: PC_DIV_B};
            end
            PC_EMIT: begin
                w = '{op: OP_EMIT, cond: COND_ALWAYS, hold: HOLD_OUTPUT, target: PC_FETCH};
            end
            PC_SEED: begin
                w = '{op: OP_SEED, cond: COND_ALWAYS, hold: HOLD_NONE, target: PC_FETCH};
            end
            default: begin
                w = '{op: OP_NONE, cond: COND_ALWAYS, hold: HOLD_NONE, target: PC_FETCH};
            end
        endcase
        return w;
    endfunction

endpackage

>>> hdl/xorshift128_bounded_random_unit.sv
// A draw runs two remainder passes of the bit-serial divider, with one further
// generator step per rejected word in between; a zero-interval draw skips the divider.
// One command at a time: a new one is taken only once the last is through, though
// an earlier result may still wait in the output register meanwhile.
// Reset (synchronous, active low) loads the generator seed words and clears the
// program counter and the output valid flag.
// ----------------------------------------------------------------------------
// xorshift128_bounded_random_unit
// Microcoded xorshift128 generator with unbiased bounded draws.
// ----------------------------------------------------------------------------
module xorshift128_bounded_random_unit
    import xbr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_command,
    input  logic [WORD_W-1:0]   i_interval,
    input  logic [WORD_W-1:0]   i_seed,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [WORD_W-1:0]   o_value
);

    logic [PC_W-1:0]      r_pc, n_pc;
    t_uword               w_uw;
    logic                 w_hold, w_cond, w_exec;

    logic [WORD_W-1:0]    r_interval, r_seed;
    logic [WORD_W-1:0]    r_w0, r_w1, r_w2, r_w3;
    logic [WORD_W-1:0]    r_limit, r_word;
    logic [WORD_W-1:0]    r_rem, r_dvd;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_out_valid;
    logic [WORD_W-1:0]    r_out_value;

    logic [WORD_W-1:0]    w_t0, w_t1, w_gen;
    logic [WORD_W:0]      w_shift, w_diff;
    logic [WORD_W-1:0]    w_rem_next;
    logic                 w_zero_iv, w_out_free;

    assign w_uw       = ucode_rom(r_pc);
    assign w_zero_iv  = (r_interval == '0);
    assign w_out_free = !r_out_valid || i_out_ready;

    // generator step
    assign w_t0  = r_w3 ^ (r_w3 << GEN_SHL);
    assign w_t1  = w_t0 ^ (w_t0 >> GEN_SHR_A);
    assign w_gen = w_t1 ^ r_w0 ^ (r_w0 >> GEN_SHR_B);

    // restoring remainder step
    assign w_shift    = {r_rem, r_dvd[WORD_W-1]};
    assign w_diff     = w_shift - {1'b0, r_interval};
    assign w_rem_next = w_diff[WORD_W] ? w_shift[WORD_W-1:0] : w_diff[WORD_W-1:0];

    // control decode
    always_comb begin
        case (w_uw.hold)
            HOLD_INPUT:  w_hold = !i_in_valid;
            HOLD_OUTPUT: w_hold = !w_out_free;
            default:     w_hold = 1'b0;
        endcase
        case (w_uw.cond)
            COND_ALWAYS:   w_cond = 1'b1;
            COND_SEED:     w_cond = (i_command == CMD_SEED);
            COND_ZERO_IV:  w_cond = w_zero_iv;
            COND_DIV_BUSY: w_cond = (r_cnt != DIV_LAST);
            COND_REJECT:   w_cond = (w_gen > r_limit);
            default:       w_cond = 1'b0;
        endcase
        w_exec = !w_hold;
    end

    // next step
    always_comb begin
        if (w_hold) begin
            n_pc = r_pc;
        end else if (w_cond) begin
            n_pc = w_uw.target;
        end else begin
            n_pc = r_pc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_FETCH;
        end else begin
            r_pc <= n_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w0 <= SEED_W0;
            r_w1 <= SEED_W1;
            r_w2 <= SEED_W2;
            r_w3 <= SEED_W3;
        end else if (w_exec && (w_uw.op == OP_GEN || w_uw.op == OP_SEED)) begin
            r_w3 <= r_w2;
            r_w2 <= r_w1;
            r_w1 <= r_w0;
            r_w0 <= (w_uw.op == OP_SEED) ? (w_gen ^ r_seed) : w_gen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            case (w_uw.op)
                OP_FETCH: begin
                    r_interval <= i_interval;
                    r_seed     <= i_seed;
                end
                OP_LIM_FULL: begin
                    r_limit <= WORD_MAX;
                end
                OP_DIV_LOAD_MAX: begin
                    r_rem <= '0;
                    r_dvd <= WORD_MAX;
                    r_cnt <= '0;
                end
                OP_DIV_LOAD_WORD: begin
                    r_rem <= '0;
                    r_dvd <= r_word;
                    r_cnt <= '0;
                end
                OP_DIV_STEP: begin
                    r_rem <= w_rem_next;
                    r_dvd <= r_dvd << 1;
                    r_cnt <= r_cnt + 1'b1;
                end
                OP_SET_LIMIT: begin
                    if (r_rem == r_interval - 1'b1) begin
                        r_limit <= WORD_MAX;
                    end else begin
                        r_limit <= WORD_MAX - (r_rem + 1'b1);
                    end
                end
                OP_GEN: begin
                    r_word <= w_gen;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_exec && w_uw.op == OP_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec && w_uw.op == OP_EMIT) begin
            r_out_value <= w_zero_iv ? r_word : r_rem;
        end
    end

    assign o_in_ready  = (r_pc == PC_FETCH);
    assign o_out_valid = r_out_valid;
    assign o_value     = r_out_value;

endmodule

>>> hdl/xbr_checker.sv
// ----------------------------------------------------------------------------
// xbr_checker
// Port-level checks of the bounded random unit, bound to the top level.
// ----------------------------------------------------------------------------
module xbr_checker
    import xbr_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              i_command,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [WORD_W-1:0] o_value
);

    logic w_in_acc;
    assign w_in_acc = i_in_valid && o_in_ready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_value))
        else $error("result dropped or changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !o_in_ready)
        else $error("transaction taken while busy");

    a_draw_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_command == CMD_DRAW |=> !o_in_ready ##1 !o_in_ready)
        else $error("draw finished too early");

    a_seed_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_command == CMD_SEED |=> !$rose(o_out_valid))
        else $error("seed command produced a result");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind xorshift128_bounded_random_unit xbr_checker u_xbr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_command   (i_command),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_value     (o_value)
);
